[rtl/core/dms_pkg.sv]
// ----------------------------------------------------------------------------
// dms_pkg
// Shared constants and types for the deadline-monotonic tick scheduler.
// ----------------------------------------------------------------------------
package dms_pkg;

  localparam int NUM_TASKS_DEF   = 4;
  localparam int MAX_PENDING_DEF = 15;

  // Descriptor registers available in the register map
  localparam int WORD_COUNT = 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int TIME_W     = 32;
  localparam int TASK_ID_W  = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TASK_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TASK_WORD_A = 3'd1;

  // Per-tick control handed to every task lane
  typedef struct packed {
    logic              advance;
    logic              clear;
    logic              load_offsets;
    logic              halt;
    logic [TIME_W-1:0] now;
  } dms_ctl_t;

  // Per-tick status returned by a task lane
  typedef struct packed {
    logic ready;
    logic ovf;
    logic miss;
  } dms_lane_stat_t;

endpackage

[rtl/core/dms_task_lane.sv]
// ----------------------------------------------------------------------------
// dms_task_lane
// State and per-tick update of one periodic task: release, pending count,
// head job remaining time and absolute deadline.
// ----------------------------------------------------------------------------
module dms_task_lane import dms_pkg::*; #(
  parameter int MAX_PENDING = MAX_PENDING_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [63:0]     desc,
  input  logic            active,
  input  dms_ctl_t        ctl,
  input  logic            sel,
  output dms_lane_stat_t  stat
);

  localparam int PW = $clog2(MAX_PENDING + 1);
  localparam logic [PW-1:0] PEND_MAX = PW'(MAX_PENDING);

  logic [TIME_W-1:0] next_release;
  logic [PW-1:0]     pending;
  logic [15:0]       head_remaining;
  logic [TIME_W-1:0] head_deadline;

  logic [TIME_W-1:0] next_release_next;
  logic [PW-1:0]     pending_next;
  logic [15:0]       head_remaining_next;
  logic [TIME_W-1:0] head_deadline_next;

  logic [15:0] offset, wcet, period, deadline;
  logic [TIME_W-1:0] nr_eff, hd_eff, hd1, late;
  logic [PW-1:0]     pend_eff, pend1;
  logic [15:0]       hr_eff, hr1;
  logic              ovf, miss;

  assign offset   = desc[63:48];
  assign wcet     = desc[47:32];
  assign period   = desc[31:16];
  assign deadline = desc[15:0];

  always_comb begin
    nr_eff   = ctl.load_offsets ? {16'b0, offset} : next_release;
    pend_eff = ctl.clear ? '0 : pending;
    hr_eff   = ctl.clear ? '0 : head_remaining;
    hd_eff   = ctl.clear ? '0 : head_deadline;

    // release
    pend1             = pend_eff;
    hr1               = hr_eff;
    hd1               = hd_eff;
    next_release_next = nr_eff;
    ovf               = 1'b0;
    if (active && !ctl.halt && nr_eff == ctl.now) begin
      if (wcet != 16'd0) begin
        if (pend_eff == '0) begin
          hr1   = wcet;
          hd1   = ctl.now + {16'b0, deadline};
          pend1 = PW'(1);
        end else if (pend_eff < PEND_MAX) begin
          pend1 = pend_eff + PW'(1);
        end else begin
          ovf = 1'b1;
        end
      end
      next_release_next = ctl.now + {16'b0, period};
    end

    // execute one unit
    late                = ctl.now + 32'd1 - hd1;
    pending_next        = pend1;
    head_remaining_next = hr1;
    head_deadline_next  = hd1;
    miss                = 1'b0;
    if (sel) begin
      if (hr1 != 16'd0) begin
        head_remaining_next = hr1 - 16'd1;
      end
      miss = (late != '0) && !late[TIME_W-1];
      if (head_remaining_next == 16'd0) begin
        pending_next = pend1 - PW'(1);
        if (pending_next != '0) begin
          if (wcet == 16'd0) begin
            pending_next = '0;
          end else begin
            head_remaining_next = wcet;
            head_deadline_next  = hd1 + {16'b0, period};
          end
        end
      end
    end

    stat.ready = active && !ctl.halt && (pend1 != '0);
    stat.ovf   = ovf;
    stat.miss  = miss;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_release   <= '0;
      pending        <= '0;
      head_remaining <= '0;
      head_deadline  <= '0;
    end else if (ctl.advance) begin
      next_release   <= next_release_next;
      pending        <= pending_next;
      head_remaining <= head_remaining_next;
      head_deadline  <= head_deadline_next;
    end
  end

endmodule

[rtl/core/deadline_monotonic_tick_scheduler_core.sv]
// ----------------------------------------------------------------------------
// deadline_monotonic_tick_scheduler_core
// Deadline-monotonic scheduler of periodic tasks, one decision per tick item.
// ----------------------------------------------------------------------------
// Each input item is one time tick and yields one result item. Ticks go
// through an input register, one pass of release, selection and update
// logic, and an output register, so a new tick is taken every cycle unless
// a result waits untaken in the output register, which decouples a stalled
// consumer. The selection among tasks is a linear compare of relative
// deadlines over NUM_TASKS lanes. The user must write configuration only
// while no tick is in flight; the block itself does not check this.
module deadline_monotonic_tick_scheduler_core import dms_pkg::*; #(
  parameter int NUM_TASKS   = NUM_TASKS_DEF,
  parameter int MAX_PENDING = MAX_PENDING_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // config
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // ticks in
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [0] clear, [7:1] zero
  // results out
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [39:0]           m_tdata    // [31:0] tick_time, [34:32] running_task,
                                           // [35] deadline_miss, [36] halted,
                                           // [37] queue_overflow, [39:38] zero
);

  logic [2:0]            task_count;
  logic [CFG_DATA_W-1:0] task_word [WORD_COUNT];

  logic              in_valid;
  logic              in_clear;
  logic              advance;

  logic [TIME_W-1:0] current_time;
  logic              started;
  logic              halt_flag;

  dms_ctl_t          ctl;
  logic [63:0]       task_desc [NUM_TASKS];
  logic              task_act  [NUM_TASKS];
  logic              task_sel  [NUM_TASKS];
  dms_lane_stat_t    stat      [NUM_TASKS];

  logic                 best_found;
  logic [TASK_ID_W-1:0] best_idx;
  logic [15:0]          best_dl;
  logic                 miss_any, ovf_any;
  logic [TASK_ID_W-1:0] running_task;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      task_count <= '0;
      for (int k = 0; k < WORD_COUNT; k++) begin
        task_word[k] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == REG_TASK_COUNT) begin
        task_count <= cfg_data[2:0];
      end
      for (int k = 0; k < WORD_COUNT; k++) begin
        if (cfg_index == REG_TASK_WORD_A + CFG_IDX_W'(k)) begin
          task_word[k] <= cfg_data;
        end
      end
    end
  end

  // input register
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_clear <= s_tdata[0];
    end
  end

  // tick control
  always_comb begin
    ctl.advance      = advance;
    ctl.clear        = in_clear;
    ctl.load_offsets = in_clear || !started;
    ctl.halt         = !in_clear && halt_flag;
    ctl.now          = in_clear ? '0 : current_time;
  end

  // task lanes
  for (genvar i = 0; i < NUM_TASKS; i++) begin : g_lane
    if (i < WORD_COUNT) begin : g_word
      assign task_desc[i] = task_word[i];
    end else begin : g_none
      assign task_desc[i] = '0;
    end
    assign task_act[i] = (TASK_ID_W'(i) < task_count) && (task_desc[i][31:16] != 16'd0);
    assign task_sel[i] = best_found && (best_idx == TASK_ID_W'(i));

    dms_task_lane #(
      .MAX_PENDING (MAX_PENDING)
    ) u_lane (
      .clk    (clk),
      .rst    (rst),
      .desc   (task_desc[i]),
      .active (task_act[i]),
      .ctl    (ctl),
      .sel    (task_sel[i]),
      .stat   (stat[i])
    );
  end

  // smallest relative deadline, lower task number wins ties
  always_comb begin
    best_found = 1'b0;
    best_idx   = '0;
    best_dl    = '0;
    for (int i = 0; i < NUM_TASKS; i++) begin
      if (stat[i].ready && (!best_found || task_desc[i][15:0] < best_dl)) begin
        best_found = 1'b1;
        best_idx   = TASK_ID_W'(i);
        best_dl    = task_desc[i][15:0];
      end
    end
    running_task = best_found ? best_idx + TASK_ID_W'(1) : '0;
  end

  always_comb begin
    miss_any = 1'b0;
    ovf_any  = 1'b0;
    for (int i = 0; i < NUM_TASKS; i++) begin
      miss_any = miss_any | stat[i].miss;
      ovf_any  = ovf_any | stat[i].ovf;
    end
  end

  // run state
  always_ff @(posedge clk) begin
    if (rst) begin
      current_time <= '0;
      started      <= 1'b0;
      halt_flag    <= 1'b0;
    end else if (advance) begin
      started      <= 1'b1;
      current_time <= ctl.halt ? ctl.now : ctl.now + 32'd1;
      halt_flag    <= ctl.halt || miss_any;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {2'b00, ovf_any, ctl.halt, miss_any, running_task, ctl.now};
    end
  end

endmodule
